/* src/lpd_pkg.sv */
// Package for the length-prefixed deframer: beat structs, codes and constants.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package lpd_pkg;

  // reset value of the frame length limit
  localparam logic [15:0] MaxFrameLenReset = 16'h3FFF;
  // the length field counts its own two bytes
  localparam logic [15:0] HeaderBytes = 16'd2;

  // kind of a result beat
  typedef enum logic [1:0] {
    KIND_PAYLOAD   = 2'd0,
    KIND_EMPTY     = 2'd1,
    KIND_SYNC_LOST = 2'd2
  } lpd_kind_e;

  // position inside a frame
  typedef enum logic [1:0] {
    PH_LEN_LO = 2'd0,
    PH_LEN_HI = 2'd1,
    PH_FIRST  = 2'd2,
    PH_REST   = 2'd3
  } lpd_phase_e;

  // input beat
  typedef struct packed {
    logic [7:0]  data_byte;
    logic        seg_start;
    logic [15:0] seg_len;
  } lpd_in_t;

  // result beat
  typedef struct packed {
    lpd_kind_e   out_kind;
    logic [7:0]  out_byte;
    logic        frame_first;
    logic        frame_last;
  } lpd_out_t;

endpackage

/* src/lpd_in_stage.sv */
// Input register of the deframer: holds one accepted input beat.
// Depends on lpd_pkg.
`timescale 1ns / 1ps

module lpd_in_stage import lpd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  lpd_in_t in_data_i,
  input  logic    pop_i,
  output logic    valid_o,
  output lpd_in_t item_o
);

  logic    valid_q, valid_d;
  lpd_in_t item_q;
  logic    load;

  // free when empty or when the held beat moves on this cycle
  assign in_ready_o = !valid_q || pop_i;
  assign load       = in_valid_i && in_ready_o;

  // occupancy
  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (pop_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= in_data_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

/* src/lpd_core.sv */
// Framing state machine of the deframer: sync tracking, length checks, result build.
// Depends on lpd_pkg.
`timescale 1ns / 1ps

module lpd_core import lpd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        step_i,
  input  lpd_in_t     item_i,
  output logic        res_valid_o,
  output lpd_out_t    res_o
);

  logic        in_sync_q, in_sync_d;
  lpd_phase_e  phase_q, phase_d;
  logic [7:0]  len_lo_q, len_lo_d;
  logic [15:0] remain_q, remain_d;
  logic        drop_q, drop_d;
  logic [15:0] seg_len_q, seg_len_d;
  logic [15:0] max_len_q;

  logic [15:0] len;
  logic        len_bad;
  logic        len_empty;
  logic        last_byte;

  // length assembled from the held low byte and this byte
  assign len       = {item_i.data_byte, len_lo_q};
  assign len_bad   = (len < HeaderBytes) || (len > max_len_q);
  assign len_empty = (len == HeaderBytes);
  assign last_byte = (remain_q <= 16'd1);

  // next state
  always_comb begin
    in_sync_d = in_sync_q;
    phase_d   = phase_q;
    len_lo_d  = len_lo_q;
    remain_d  = remain_q;
    drop_d    = drop_q;
    seg_len_d = seg_len_q;
    if (!in_sync_q) begin
      if (item_i.seg_start) begin
        // trial: first byte of the segment is the low length byte
        seg_len_d = item_i.seg_len;
        len_lo_d  = item_i.data_byte;
        phase_d   = PH_LEN_HI;
        drop_d    = 1'b0;
      end else if (drop_q || (phase_q != PH_LEN_HI)) begin
        drop_d  = 1'b1;
        phase_d = PH_LEN_LO;
      end else if ((len != seg_len_q) || len_bad) begin
        drop_d  = 1'b1;
        phase_d = PH_LEN_LO;
      end else begin
        in_sync_d = 1'b1;
        if (len_empty) begin
          phase_d = PH_LEN_LO;
        end else begin
          remain_d = len - HeaderBytes;
          phase_d  = PH_FIRST;
        end
      end
    end else begin
      case (phase_q)
        PH_LEN_LO: begin
          len_lo_d = item_i.data_byte;
          phase_d  = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          if (len_bad) begin
            in_sync_d = 1'b0;
            drop_d    = 1'b1;
            phase_d   = PH_LEN_LO;
            remain_d  = 16'd0;
          end else if (len_empty) begin
            phase_d = PH_LEN_LO;
          end else begin
            remain_d = len - HeaderBytes;
            phase_d  = PH_FIRST;
          end
        end
        default: begin
          if (last_byte) begin
            remain_d = 16'd0;
            phase_d  = PH_LEN_LO;
          end else begin
            remain_d = remain_q - 16'd1;
            phase_d  = PH_REST;
          end
        end
      endcase
    end
  end

  // result for this beat
  always_comb begin
    res_valid_o       = 1'b0;
    res_o.out_kind    = KIND_PAYLOAD;
    res_o.out_byte    = 8'd0;
    res_o.frame_first = 1'b0;
    res_o.frame_last  = 1'b0;
    if (!in_sync_q) begin
      if (!item_i.seg_start && !drop_q && (phase_q == PH_LEN_HI) &&
          (len == seg_len_q) && !len_bad && len_empty) begin
        res_valid_o    = 1'b1;
        res_o.out_kind = KIND_EMPTY;
      end
    end else begin
      case (phase_q)
        PH_LEN_LO: begin
          res_valid_o = 1'b0;
        end
        PH_LEN_HI: begin
          if (len_bad) begin
            res_valid_o    = 1'b1;
            res_o.out_kind = KIND_SYNC_LOST;
          end else if (len_empty) begin
            res_valid_o    = 1'b1;
            res_o.out_kind = KIND_EMPTY;
          end
        end
        default: begin
          res_valid_o       = 1'b1;
          res_o.out_byte    = item_i.data_byte;
          res_o.frame_first = (phase_q == PH_FIRST);
          res_o.frame_last  = last_byte;
        end
      endcase
    end
  end

  // framing state, updated once per beat that leaves the input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_sync_q <= 1'b0;
      phase_q   <= PH_LEN_LO;
      len_lo_q  <= 8'd0;
      remain_q  <= 16'd0;
      drop_q    <= 1'b1;
      seg_len_q <= 16'd0;
    end else if (step_i) begin
      in_sync_q <= in_sync_d;
      phase_q   <= phase_d;
      len_lo_q  <= len_lo_d;
      remain_q  <= remain_d;
      drop_q    <= drop_d;
      seg_len_q <= seg_len_d;
    end
  end

  // frame length limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MaxFrameLenReset;
    end else if (cfg_we_i) begin
      max_len_q <= cfg_wdata_i;
    end
  end

endmodule

/* src/lpd_out_stage.sv */
// Result register of the deframer: holds one result beat until it is taken.
// Depends on lpd_pkg.
`timescale 1ns / 1ps

module lpd_out_stage import lpd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     load_i,
  input  lpd_out_t res_i,
  output logic     free_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output lpd_out_t out_data_o
);

  logic     valid_q, valid_d;
  lpd_out_t res_q;

  // slot can take a new beat when empty or draining this cycle
  assign free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = res_q;

endmodule

/* src/length_prefixed_deframer.sv */
// Length-prefixed deframer: input register, framing core, result register.
// A result beat passes through the input register and then the result register before it shows on out_valid_o.
// Throughput: 1 input beat per cycle while the result side is ready.
// Reset: out of sync, dropping until a segment start; frame length limit 16383.
// Depends on lpd_pkg, lpd_in_stage, lpd_core, lpd_out_stage.
`timescale 1ns / 1ps

module length_prefixed_deframer import lpd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  lpd_in_t     in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output lpd_out_t    out_data_o
);

  logic     held_valid;
  lpd_in_t  held_item;
  logic     slot_free;
  logic     step;
  logic     res_valid;
  lpd_out_t res;

  // a held beat advances when the result slot can take its result
  assign step = held_valid && slot_free;

  lpd_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .pop_i      (step),
    .valid_o    (held_valid),
    .item_o     (held_item)
  );

  lpd_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .step_i      (step),
    .item_i      (held_item),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  lpd_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step && res_valid),
    .res_i       (res),
    .free_o      (slot_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
